// File: design/mfe_pkg.sv
// mfe_pkg: shared types, constants and functions of the measurement frame encoder
// used by mfe_cell and measurement_frame_encoder; no dependencies

package mfe_pkg;

	localparam int unsigned WordsPerPoint = 6;
	localparam int unsigned BytesPerWord  = 5;
	localparam int unsigned DataBytes     = WordsPerPoint * BytesPerWord;
	localparam int unsigned GroupBits     = 7;

	localparam logic [7:0] GroupMask = 8'h7F;
	localparam logic [7:0] HighBit   = 8'h80;
	localparam logic [7:0] CheckInit = 8'b0100_0110;

	// one measurement point, fields in frame order (first field in the msbs)
	typedef struct packed {
		logic signed [31:0] fwd_re;
		logic signed [31:0] fwd_im;
		logic signed [31:0] refl_re;
		logic signed [31:0] refl_im;
		logic signed [31:0] thru_re;
		logic signed [31:0] thru_im;
	} point_t;

	// one byte of the outgoing frame
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_t;

	// contents of one cell of the byte row
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} cell_t;

	// 7-bit group of a sign-extended word at an arithmetic shift of 7 * grp
	function automatic logic [6:0] group_bits(input logic [31:0] word, input logic [2:0] grp);
		logic [34:0] ext;
		logic [34:0] shifted;
		ext     = {{3{word[31]}}, word};
		shifted = ext >> (GroupBits * grp);
		return shifted[6:0];
	endfunction

	// running checksum step over one data byte
	function automatic logic [7:0] check_next(input logic [7:0] chk, input logic [7:0] data);
		return (chk ^ {chk[6:0], 1'b1}) ^ data;
	endfunction

endpackage

// File: design/mfe_cell.sv
// mfe_cell: one byte cell of the frame row, loaded in parallel and shifted toward the head
// depends on mfe_pkg

module mfe_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          shift,
	input  mfe_pkg::cell_t load_val,
	input  mfe_pkg::cell_t next,
	output mfe_pkg::cell_t cur
);

	logic       vld_q;
	logic [7:0] data_q;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= load_val.vld;
		end else if (shift) begin
			vld_q <= next.vld;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_val.data;
		end else if (shift) begin
			data_q <= next.data;
		end
	end

	assign cur.vld  = vld_q;
	assign cur.data = data_q;

endmodule

// File: design/measurement_frame_encoder.sv
// measurement_frame_encoder: top level, a row of byte cells with a serial checksum and output register
// depends on mfe_pkg and mfe_cell

// Each accepted point is split into 30 data bytes that load at once into a row
// of 30 byte cells; the row shifts one byte per cycle toward an output register
// while the output is not stalled and no checksum is pending, and a running
// checksum follows the bytes as they leave, going out as the 31st byte with
// frame_last set. The next point is taken in the same cycle that the last data
// byte leaves the row, so back-to-back points stream with no gap while
// frame_ready stays high.

module measurement_frame_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            point_valid,
	output logic            point_ready,
	input  mfe_pkg::point_t point,
	output logic            frame_valid,
	input  logic            frame_ready,
	output mfe_pkg::frame_t frame
);

	localparam int unsigned NumCells = mfe_pkg::DataBytes;

	logic [mfe_pkg::WordsPerPoint-1:0][31:0] words;
	mfe_pkg::cell_t [NumCells-1:0] load_vals;
	mfe_pkg::cell_t [NumCells:0]   cells;

	logic            load;
	logic            shift;
	logic            src_valid;
	mfe_pkg::frame_t src;
	logic            adv;
	logic            take;

	logic            chk_pend_q;
	logic [7:0]      chk_q;
	logic            frame_valid_q;
	mfe_pkg::frame_t frame_q;

	// words in frame order
	assign words[0] = point.fwd_re;
	assign words[1] = point.fwd_im;
	assign words[2] = point.refl_re;
	assign words[3] = point.refl_im;
	assign words[4] = point.thru_re;
	assign words[5] = point.thru_im;

	// byte row, cell 0 at the head; the slot past the tail reads empty
	assign cells[NumCells] = '0;

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		localparam int unsigned WordIdx  = k / mfe_pkg::BytesPerWord;
		localparam int unsigned GroupIdx = k % mfe_pkg::BytesPerWord;
		localparam logic        SyncByte = (k == 0);

		// first byte keeps bit 7 clear as frame sync
		assign load_vals[k].vld  = 1'b1;
		assign load_vals[k].data = {~SyncByte,
			mfe_pkg::group_bits(words[WordIdx], GroupIdx[2:0])};

		mfe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.shift    (shift),
			.load_val (load_vals[k]),
			.next     (cells[k+1]),
			.cur      (cells[k])
		);
	end

	// next byte for the output register: pending checksum goes first
	always_comb begin
		src_valid = chk_pend_q || cells[0].vld;
		if (chk_pend_q) begin
			src.frame_byte = chk_q | mfe_pkg::HighBit;
			src.frame_last = 1'b1;
		end else begin
			src.frame_byte = cells[0].data;
			src.frame_last = 1'b0;
		end
	end

	// handshake and row control
	assign adv         = !frame_valid_q || frame_ready;
	assign take        = adv && src_valid;
	assign shift       = take && !chk_pend_q;
	assign point_ready = !cells[0].vld || (shift && !cells[1].vld);
	assign load        = point_valid && point_ready;

	// running checksum, pending once the last data byte has left the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_pend_q <= 1'b0;
			chk_q      <= mfe_pkg::CheckInit;
		end else if (take && chk_pend_q) begin
			chk_pend_q <= 1'b0;
			chk_q      <= mfe_pkg::CheckInit;
		end else if (shift) begin
			chk_q <= mfe_pkg::check_next(chk_q, cells[0].data);
			if (!cells[1].vld) begin
				chk_pend_q <= 1'b1;
			end
		end
	end

	// output register flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (adv) begin
			frame_valid_q <= src_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			frame_q <= src;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

endmodule
